/* rtl/mp3_side_info_parser_assert.svh */
// Assertion macros used by the side-information parser's extractor module.
`ifndef MP3_SIDE_INFO_PARSER_ASSERT_SVH
`define MP3_SIDE_INFO_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MPSI_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("side-information parser check failed");
`define MPSI_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("side-information parser check failed");
`else
`define MPSI_ASSERT_RST(label, clk, rst, prop)
`define MPSI_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/mpsi_pkg.sv */
// Types, field codes and the field width table of the side-information parser.
package mpsi_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       frame_start;
    logic       mono;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  field_code;
    logic        granule;
    logic        channel;
    logic [1:0]  slot;
    logic [11:0] value;
    logic        last_of_item;
    logic        frame_done;
  } out_item_t;

  localparam logic [3:0] FC_MAIN_DATA_BEGIN   = 4'd0;
  localparam logic [3:0] FC_SCFSI             = 4'd1;
  localparam logic [3:0] FC_PART2_3_LENGTH    = 4'd2;
  localparam logic [3:0] FC_BIG_VALUES        = 4'd3;
  localparam logic [3:0] FC_GLOBAL_GAIN       = 4'd4;
  localparam logic [3:0] FC_SCALEFAC_COMPRESS = 4'd5;
  localparam logic [3:0] FC_WINDOW_SWITCHING  = 4'd6;
  localparam logic [3:0] FC_BLOCK_TYPE        = 4'd7;
  localparam logic [3:0] FC_MIXED             = 4'd8;
  localparam logic [3:0] FC_TABLE_SELECT      = 4'd9;
  localparam logic [3:0] FC_SUBBLOCK_GAIN     = 4'd10;
  localparam logic [3:0] FC_REGION0           = 4'd11;
  localparam logic [3:0] FC_REGION1           = 4'd12;
  localparam logic [3:0] FC_PREFLAG           = 4'd13;
  localparam logic [3:0] FC_SCALEFAC_SCALE    = 4'd14;
  localparam logic [3:0] FC_COUNT1TABLE       = 4'd15;

  // Results that one byte may produce at most.
  localparam logic [3:0] MAX_RESULTS = 4'd8;

  typedef enum logic [4:0] {
    ST_MDB, ST_PRIV, ST_SCFSI, ST_P23, ST_BIGV, ST_GGAIN, ST_SFC, ST_WS,
    ST_BT, ST_MIXED, ST_TSEL, ST_SBG, ST_R0, ST_R1, ST_PRE, ST_SFS, ST_C1T
  } step_t;

  function automatic logic [3:0] step_width(input step_t step, input logic mono);
    logic [3:0] w;
    case (step)
      ST_MDB:   w = 4'd9;
      ST_PRIV:  w = mono ? 4'd5 : 4'd3;
      ST_SCFSI: w = 4'd4;
      ST_P23:   w = 4'd12;
      ST_BIGV:  w = 4'd9;
      ST_GGAIN: w = 4'd8;
      ST_SFC:   w = 4'd4;
      ST_WS:    w = 4'd1;
      ST_BT:    w = 4'd2;
      ST_MIXED: w = 4'd1;
      ST_TSEL:  w = 4'd5;
      ST_SBG:   w = 4'd3;
      ST_R0:    w = 4'd4;
      ST_R1:    w = 4'd3;
      ST_PRE:   w = 4'd1;
      ST_SFS:   w = 4'd1;
      ST_C1T:   w = 4'd1;
      default:  w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/mp3_side_info_parser.sv */
// Top level of the MPEG-1 Layer III side-information field parser.
// The parser takes side-information bytes, most significant bit first, and
// returns every field that each byte completes, tagged with its code, granule,
// channel and slot; the private bits are skipped, and bytes outside a frame
// are dropped. A byte with frame_start high restarts parsing and latches mono.
// Bytes enter an input queue; the extractor behind it loads one byte and
// pulls out one field per cycle while the output queue is not full, the
// skipped private bits counting as one field; it loads the next byte only
// when the current one can yield no further field. The single field
// extractor, with its shift and compare on the bit accumulator, sets this
// rate. Fields are held back one step so that last_of_item can be marked,
// then pass through an output queue; a full output queue stalls the
// extractor but the input queue keeps taking items until it fills.
module mp3_side_info_parser #(
  parameter int IN_DEPTH  = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mpsi_pkg::in_item_t  byte_item,
  output logic                empty,
  input  logic                pop,
  output mpsi_pkg::out_item_t field_item
);
  import mpsi_pkg::*;

  in_item_t  q_item;
  logic      q_valid;
  logic      q_pop;
  logic      res_wr;
  logic      res_full;
  out_item_t res_item;
  logic      out_valid;

  // Front: input queue that accepts bytes independently of the extractor.
  mpsi_queue #(
    .DEPTH  (IN_DEPTH),
    .item_t (in_item_t)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .wr       (push),
    .full     (full),
    .wr_item  (byte_item),
    .rd_valid (q_valid),
    .rd       (q_pop),
    .rd_item  (q_item)
  );

  // Back: bit accumulator and field sequencer.
  mpsi_extract u_extract (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_item  (q_item),
    .in_pop   (q_pop),
    .res_wr   (res_wr),
    .res_item (res_item),
    .res_full (res_full)
  );

  // Result queue; the oldest field is presented while empty is low.
  mpsi_queue #(
    .DEPTH  (OUT_DEPTH),
    .item_t (out_item_t)
  ) u_results (
    .clk      (clk),
    .rst      (rst),
    .wr       (res_wr),
    .full     (res_full),
    .wr_item  (res_item),
    .rd_valid (out_valid),
    .rd       (pop),
    .rd_item  (field_item)
  );

  assign empty = !out_valid;

endmodule

/* rtl/mpsi_queue.sv */
// Small first-in first-out queue of flip-flops, used on both sides of the extractor.
module mpsi_queue #(
  parameter int DEPTH = 4,
  parameter type item_t = logic [7:0]
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  output logic  full,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd,
  output item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

/* rtl/mpsi_extract.sv */
// Bit accumulator and field sequencer: takes bytes, yields one field per cycle while res_full is low.
`include "mp3_side_info_parser_assert.svh"

module mpsi_extract (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  mpsi_pkg::in_item_t  in_item,
  output logic                in_pop,
  output logic                res_wr,
  output mpsi_pkg::out_item_t res_item,
  input  logic                res_full
);
  import mpsi_pkg::*;

  // Sequencer state.
  logic [19:0] acc;
  logic [4:0]  held;
  step_t       step;
  logic        gr;
  logic        ch;
  logic [1:0]  sl;
  logic        sw;
  logic        mono_l;
  logic        active;
  logic        busy;
  logic [3:0]  cnt;
  logic        pend_valid;
  out_item_t   pend;

  // Next values.
  logic [19:0] acc_next;
  logic [4:0]  held_next;
  step_t       step_next;
  logic        gr_next;
  logic        ch_next;
  logic [1:0]  sl_next;
  logic        sw_next;
  logic        mono_l_next;
  logic        active_next;
  logic        busy_next;
  logic [3:0]  cnt_next;
  logic        pend_valid_next;

  // State as seen by the extractor this cycle, after any byte is loaded.
  logic [19:0] v_acc;
  logic [4:0]  v_held;
  step_t       v_step;
  logic        v_gr;
  logic        v_ch;
  logic [1:0]  v_sl;
  logic        v_sw;
  logic        v_mono;
  logic        v_active;
  logic [3:0]  v_cnt;

  logic        advance;
  logic [3:0]  n_cur;
  logic [3:0]  n_v;
  logic        can_cur;
  logic        kill;
  logic        load;
  logic        close;
  logic        do_ext;
  logic        emit;
  logic [4:0]  rem;
  logic [19:0] shifted;
  logic [11:0] fval;
  out_item_t   r;

  assign advance = !res_full;
  assign n_cur   = step_width(step, mono_l);
  assign can_cur = advance && busy && active && (n_cur != 4'd0) &&
                   (held >= {1'b0, n_cur}) && (cnt != MAX_RESULTS);
  assign kill    = advance && busy && active && (n_cur == 4'd0);
  assign load    = advance && !can_cur && in_valid;
  assign close   = advance && busy && !can_cur;
  assign in_pop  = load;

  // Clear the view on an invalid step, then load the next byte into it, applying a frame start first.
  always_comb begin
    v_acc    = acc;
    v_held   = held;
    v_step   = step;
    v_gr     = gr;
    v_ch     = ch;
    v_sl     = sl;
    v_sw     = sw;
    v_mono   = mono_l;
    v_active = active;
    v_cnt    = cnt;
    if (kill) begin
      v_acc    = '0;
      v_held   = '0;
      v_step   = ST_MDB;
      v_gr     = 1'b0;
      v_ch     = 1'b0;
      v_sl     = '0;
      v_sw     = 1'b0;
      v_active = 1'b0;
    end
    if (load) begin
      v_cnt = '0;
      if (in_item.frame_start) begin
        v_acc    = '0;
        v_held   = '0;
        v_step   = ST_MDB;
        v_gr     = 1'b0;
        v_ch     = 1'b0;
        v_sl     = '0;
        v_sw     = 1'b0;
        v_mono   = in_item.mono;
        v_active = 1'b1;
      end
      if (v_active) begin
        v_acc  = {v_acc[11:0], in_item.byte_in};
        v_held = v_held + 5'd8;
      end
    end
  end

  assign n_v    = step_width(v_step, v_mono);
  assign do_ext = can_cur ||
                  (load && v_active && (n_v != 4'd0) && (v_held >= {1'b0, n_v}));
  assign rem     = v_held - {1'b0, n_v};
  assign shifted = v_acc >> rem;
  assign fval    = shifted[11:0] & ((12'd1 << n_v) - 12'd1);

  // Field sequencer.
  always_comb begin
    acc_next    = v_acc;
    held_next   = v_held;
    step_next   = v_step;
    gr_next     = v_gr;
    ch_next     = v_ch;
    sl_next     = v_sl;
    sw_next     = v_sw;
    mono_l_next = v_mono;
    active_next = v_active;
    emit        = 1'b0;
    r           = '0;
    r.granule   = v_gr;
    r.channel   = v_ch;
    r.value     = fval;
    if (do_ext) begin
      held_next = rem;
      acc_next  = v_acc & ((20'd1 << rem) - 20'd1);
      emit      = 1'b1;
      case (v_step)
        ST_MDB: begin
          r.field_code = FC_MAIN_DATA_BEGIN;
          r.granule    = 1'b0;
          r.channel    = 1'b0;
          step_next    = ST_PRIV;
        end
        ST_PRIV: begin
          emit      = 1'b0;
          ch_next   = 1'b0;
          step_next = ST_SCFSI;
        end
        ST_SCFSI: begin
          r.field_code = FC_SCFSI;
          r.granule    = 1'b0;
          if (v_mono || v_ch) begin
            ch_next   = 1'b0;
            gr_next   = 1'b0;
            step_next = ST_P23;
          end else begin
            ch_next = 1'b1;
          end
        end
        ST_P23: begin
          r.field_code = FC_PART2_3_LENGTH;
          step_next    = ST_BIGV;
        end
        ST_BIGV: begin
          r.field_code = FC_BIG_VALUES;
          step_next    = ST_GGAIN;
        end
        ST_GGAIN: begin
          r.field_code = FC_GLOBAL_GAIN;
          step_next    = ST_SFC;
        end
        ST_SFC: begin
          r.field_code = FC_SCALEFAC_COMPRESS;
          step_next    = ST_WS;
        end
        ST_WS: begin
          r.field_code = FC_WINDOW_SWITCHING;
          sw_next      = fval[0];
          sl_next      = '0;
          step_next    = fval[0] ? ST_BT : ST_TSEL;
        end
        ST_BT: begin
          r.field_code = FC_BLOCK_TYPE;
          step_next    = ST_MIXED;
        end
        ST_MIXED: begin
          r.field_code = FC_MIXED;
          step_next    = ST_TSEL;
        end
        ST_TSEL: begin
          r.field_code = FC_TABLE_SELECT;
          r.slot       = v_sl;
          if (v_sw ? (v_sl == 2'd0) : (v_sl < 2'd2)) begin
            sl_next = v_sl + 2'd1;
          end else begin
            sl_next   = '0;
            step_next = v_sw ? ST_SBG : ST_R0;
          end
        end
        ST_SBG: begin
          r.field_code = FC_SUBBLOCK_GAIN;
          r.slot       = v_sl;
          if (v_sl < 2'd2) begin
            sl_next = v_sl + 2'd1;
          end else begin
            sl_next   = '0;
            step_next = ST_PRE;
          end
        end
        ST_R0: begin
          r.field_code = FC_REGION0;
          step_next    = ST_R1;
        end
        ST_R1: begin
          r.field_code = FC_REGION1;
          step_next    = ST_PRE;
        end
        ST_PRE: begin
          r.field_code = FC_PREFLAG;
          step_next    = ST_SFS;
        end
        ST_SFS: begin
          r.field_code = FC_SCALEFAC_SCALE;
          step_next    = ST_C1T;
        end
        ST_C1T: begin
          r.field_code = FC_COUNT1TABLE;
          if (!v_mono && !v_ch) begin
            ch_next   = 1'b1;
            step_next = ST_P23;
          end else if (!v_gr) begin
            ch_next   = 1'b0;
            gr_next   = 1'b1;
            step_next = ST_P23;
          end else begin
            // End of the frame's side information; what is left is dropped.
            r.frame_done = 1'b1;
            acc_next     = '0;
            held_next    = '0;
            step_next    = ST_MDB;
            gr_next      = 1'b0;
            ch_next      = 1'b0;
            sl_next      = '0;
            sw_next      = 1'b0;
            active_next  = 1'b0;
          end
        end
        default: begin
          emit        = 1'b0;
          acc_next    = '0;
          held_next   = '0;
          step_next   = ST_MDB;
          gr_next     = 1'b0;
          ch_next     = 1'b0;
          sl_next     = '0;
          sw_next     = 1'b0;
          active_next = 1'b0;
        end
      endcase
    end
  end

  // The newest field waits in pend until it is known whether it is the last of its byte.
  assign res_wr          = pend_valid && (close || (do_ext && emit));
  assign pend_valid_next = (do_ext && emit) ? 1'b1 : (close ? 1'b0 : pend_valid);
  assign cnt_next        = v_cnt + {3'd0, emit};
  assign busy_next       = load ? v_active : (close ? 1'b0 : busy);

  always_comb begin
    res_item              = pend;
    res_item.last_of_item = close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      held       <= '0;
      step       <= ST_MDB;
      gr         <= 1'b0;
      ch         <= 1'b0;
      sl         <= '0;
      sw         <= 1'b0;
      mono_l     <= 1'b0;
      active     <= 1'b0;
      busy       <= 1'b0;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else if (advance) begin
      acc        <= acc_next;
      held       <= held_next;
      step       <= step_next;
      gr         <= gr_next;
      ch         <= ch_next;
      sl         <= sl_next;
      sw         <= sw_next;
      mono_l     <= mono_l_next;
      active     <= active_next;
      busy       <= busy_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ext && emit) begin
      pend <= r;
    end
  end

  `MPSI_ASSERT_RST(a_no_write_when_full, clk, rst, res_wr |-> !res_full)
  `MPSI_ASSERT_RST(a_pop_only_after_byte, clk, rst, in_pop |-> !can_cur)
  `MPSI_ASSERT_RST(a_done_ends_frame, clk, rst, (do_ext && emit && r.frame_done) |=> !active)
  `MPSI_ASSERT_ALWAYS(a_held_fits, clk, rst || (held <= 5'd19))

endmodule

/* bench/mpsi_field_checker.sv */
`timescale 1ns / 100ps
// Field predictor and scoreboard for the side-information parser channels.
module mpsi_field_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  mpsi_pkg::in_item_t  byte_item,
  input  logic                empty,
  input  logic                pop,
  input  mpsi_pkg::out_item_t field_item,
  output int                  error_count,
  output int                  fields_waiting
);
  import mpsi_pkg::*;

  // Own copy of the parser state.
  logic [19:0] acc;
  logic [4:0]  held;
  step_t       step;
  logic        gr_idx;
  logic        ch_idx;
  logic [1:0]  slot_idx;
  logic        sw_flag;
  logic        mono_l;
  logic        in_frame;

  out_item_t expected_fields[$];

  initial begin
    error_count    = 0;
    fields_waiting = 0;
  end

  function automatic logic [3:0] field_bits(input step_t s, input logic m);
    case (s)
      ST_MDB:   return 4'd9;
      ST_PRIV:  return m ? 4'd5 : 4'd3;
      ST_SCFSI: return 4'd4;
      ST_P23:   return 4'd12;
      ST_BIGV:  return 4'd9;
      ST_GGAIN: return 4'd8;
      ST_SFC:   return 4'd4;
      ST_BT:    return 4'd2;
      ST_TSEL:  return 4'd5;
      ST_SBG:   return 4'd3;
      ST_R0:    return 4'd4;
      ST_R1:    return 4'd3;
      ST_WS, ST_MIXED, ST_PRE, ST_SFS, ST_C1T: return 4'd1;
      default:  return 4'd0;
    endcase
  endfunction

  function automatic out_item_t make_field(input logic [3:0] code, input logic g,
                                           input logic c, input logic [1:0] sl,
                                           input logic [11:0] v, input logic done);
    out_item_t f;
    f.field_code   = code;
    f.granule      = g;
    f.channel      = c;
    f.slot         = sl;
    f.value        = v;
    f.last_of_item = 1'b0;
    f.frame_done   = done;
    return f;
  endfunction

  function automatic string describe(input out_item_t f);
    return $sformatf("code %0d gr %0d ch %0d slot %0d value 0x%03h last %0d done %0d",
                     f.field_code, f.granule, f.channel, f.slot, f.value,
                     f.last_of_item, f.frame_done);
  endfunction

  task automatic clear_sequence();
    acc      = '0;
    held     = '0;
    step     = ST_MDB;
    gr_idx   = 1'b0;
    ch_idx   = 1'b0;
    slot_idx = 2'd0;
    sw_flag  = 1'b0;
  endtask

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: field check failed: %s", $realtime, msg);
  endtask

  // Appends one byte and queues every field it completes.
  task automatic parse_byte(input in_item_t it);
    out_item_t   found[$];
    out_item_t   tail;
    logic [3:0]  n;
    logic [19:0] shifted;
    logic [11:0] v;
    logic        g;
    logic        c;
    logic [1:0]  sl;
    logic        last_ch;
    bit          run;
    if (it.frame_start) begin
      clear_sequence();
      mono_l   = it.mono;
      in_frame = 1'b1;
    end
    if (in_frame) begin
      acc     = {acc[11:0], it.byte_in};
      held    = held + 5'd8;
      last_ch = ~mono_l;
      run     = 1'b1;
      while (run && in_frame && found.size() < MAX_RESULTS) begin
        n  = field_bits(step, mono_l);
        g  = gr_idx;
        c  = ch_idx;
        sl = slot_idx;
        if (n == 4'd0) begin
          clear_sequence();
          in_frame = 1'b0;
        end else if (held < n) begin
          run = 1'b0;
        end else begin
          shifted = acc >> (held - n);
          v       = shifted[11:0] & ((12'd1 << n) - 12'd1);
          held    = held - n;
          acc     = acc & ((20'd1 << held) - 20'd1);
          case (step)
            ST_MDB: begin
              found.push_back(make_field(FC_MAIN_DATA_BEGIN, 1'b0, 1'b0, 2'd0, v, 1'b0));
              step = ST_PRIV;
            end
            ST_PRIV: begin
              ch_idx = 1'b0;
              step   = ST_SCFSI;
            end
            ST_SCFSI: begin
              found.push_back(make_field(FC_SCFSI, 1'b0, c, 2'd0, v, 1'b0));
              if (c >= last_ch) begin
                ch_idx = 1'b0;
                gr_idx = 1'b0;
                step   = ST_P23;
              end else begin
                ch_idx = 1'b1;
              end
            end
            ST_P23: begin
              found.push_back(make_field(FC_PART2_3_LENGTH, g, c, 2'd0, v, 1'b0));
              step = ST_BIGV;
            end
            ST_BIGV: begin
              found.push_back(make_field(FC_BIG_VALUES, g, c, 2'd0, v, 1'b0));
              step = ST_GGAIN;
            end
            ST_GGAIN: begin
              found.push_back(make_field(FC_GLOBAL_GAIN, g, c, 2'd0, v, 1'b0));
              step = ST_SFC;
            end
            ST_SFC: begin
              found.push_back(make_field(FC_SCALEFAC_COMPRESS, g, c, 2'd0, v, 1'b0));
              step = ST_WS;
            end
            ST_WS: begin
              found.push_back(make_field(FC_WINDOW_SWITCHING, g, c, 2'd0, v, 1'b0));
              sw_flag  = v[0];
              slot_idx = 2'd0;
              step     = sw_flag ? ST_BT : ST_TSEL;
            end
            ST_BT: begin
              found.push_back(make_field(FC_BLOCK_TYPE, g, c, 2'd0, v, 1'b0));
              step = ST_MIXED;
            end
            ST_MIXED: begin
              found.push_back(make_field(FC_MIXED, g, c, 2'd0, v, 1'b0));
              step = ST_TSEL;
            end
            ST_TSEL: begin
              found.push_back(make_field(FC_TABLE_SELECT, g, c, sl, v, 1'b0));
              if (sl != (sw_flag ? 2'd1 : 2'd2)) begin
                slot_idx = sl + 2'd1;
              end else begin
                slot_idx = 2'd0;
                step     = sw_flag ? ST_SBG : ST_R0;
              end
            end
            ST_SBG: begin
              found.push_back(make_field(FC_SUBBLOCK_GAIN, g, c, sl, v, 1'b0));
              if (sl < 2'd2) begin
                slot_idx = sl + 2'd1;
              end else begin
                slot_idx = 2'd0;
                step     = ST_PRE;
              end
            end
            ST_R0: begin
              found.push_back(make_field(FC_REGION0, g, c, 2'd0, v, 1'b0));
              step = ST_R1;
            end
            ST_R1: begin
              found.push_back(make_field(FC_REGION1, g, c, 2'd0, v, 1'b0));
              step = ST_PRE;
            end
            ST_PRE: begin
              found.push_back(make_field(FC_PREFLAG, g, c, 2'd0, v, 1'b0));
              step = ST_SFS;
            end
            ST_SFS: begin
              found.push_back(make_field(FC_SCALEFAC_SCALE, g, c, 2'd0, v, 1'b0));
              step = ST_C1T;
            end
            ST_C1T: begin
              if (c < last_ch) begin
                found.push_back(make_field(FC_COUNT1TABLE, g, c, 2'd0, v, 1'b0));
                ch_idx = 1'b1;
                step   = ST_P23;
              end else if (g == 1'b0) begin
                found.push_back(make_field(FC_COUNT1TABLE, g, c, 2'd0, v, 1'b0));
                ch_idx = 1'b0;
                gr_idx = 1'b1;
                step   = ST_P23;
              end else begin
                found.push_back(make_field(FC_COUNT1TABLE, g, c, 2'd0, v, 1'b1));
                clear_sequence();
                in_frame = 1'b0;
              end
            end
            default: begin
              clear_sequence();
              in_frame = 1'b0;
            end
          endcase
        end
      end
    end
    if (found.size() > 0) begin
      tail = found.pop_back();
      tail.last_of_item = 1'b1;
      found.push_back(tail);
    end
    foreach (found[k]) expected_fields.push_back(found[k]);
  endtask

  // Results are checked before the byte of the same edge is predicted, so a
  // result can never be matched against fields of a byte only just accepted.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_sequence();
      mono_l   = 1'b0;
      in_frame = 1'b0;
      expected_fields.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_fields.size() == 0) begin
          note_failure({"unexpected result: ", describe(field_item)});
        end else begin
          want = expected_fields.pop_front();
          if (field_item.field_code !== want.field_code ||
              field_item.granule !== want.granule ||
              field_item.channel !== want.channel ||
              field_item.slot !== want.slot ||
              field_item.value !== want.value ||
              field_item.last_of_item !== want.last_of_item ||
              field_item.frame_done !== want.frame_done) begin
            note_failure({"expected ", describe(want), ", got ", describe(field_item)});
          end
        end
      end
      if (push && !full) parse_byte(byte_item);
    end
    fields_waiting = expected_fields.size();
  end

endmodule

/* bench/mp3_side_info_parser_test.sv */
`timescale 1ns / 100ps
// Testbench top of the side-information parser: stimulus, pacing and the verdict.
module mp3_side_info_parser_test;
  import mpsi_pkg::*;

  // Longest stretch without any handshake before the run is declared hung.
  // It is set well above the deliberate output hold-off and the longest
  // sender gap, so it leaves a wide margin.
  localparam int STALL_LIMIT = 2000;
  // Bytes sent inside frames before the random part stops.
  localparam int FRAME_BYTES = 180;
  localparam int HOLD_OFF    = 150;

  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_item_t  byte_item = '0;
  logic      full;
  logic      empty;
  out_item_t field_item;
  int        error_count;
  int        fields_waiting;
  int        frame_bytes_sent = 0;

  mp3_side_info_parser i_dut (
    .clk,
    .rst,
    .push,
    .full,
    .byte_item,
    .empty,
    .pop,
    .field_item
  );

  mpsi_field_checker i_check (
    .clk,
    .rst,
    .push,
    .full,
    .byte_item,
    .empty,
    .pop,
    .field_item,
    .error_count,
    .fields_waiting
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Idle gaps: mostly none or short, now and then a long one. In a burst
  // there is no idling at all, so back-to-back traffic is seen as well.
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Offers one item at the falling edge and holds it until the rising edge
  // at which full is low. Push stays high across a zero gap, so it is never
  // lowered and raised within the same time step.
  task automatic send_byte(input logic [7:0] b, input logic fs, input logic m,
                           input bit burst);
    int gap;
    byte_item <= '{byte_in: b, frame_start: fs, mono: m};
    push      <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    @(negedge clk);
    gap = pick_gap(burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sends one frame's side information, or the first part of it when the
  // length is short. Only the first item carries the frame start; the mono
  // bit of the others is random, as the block must ignore it there.
  task automatic send_frame(input bit is_mono, input int length, input fill_t fill,
                            input bit burst);
    logic [7:0] b;
    for (int k = 0; k < length; k++) begin
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom);
      endcase
      if (k == 0) begin
        send_byte(b, 1'b1, is_mono, burst);
      end else begin
        send_byte(b, 1'b0, 1'($urandom_range(1)), burst);
      end
    end
    frame_bytes_sent += length;
  endtask

  // Sender. A mono frame is 136 bits, 17 bytes, and a stereo frame is
  // 256 bits, 32 bytes, whichever way each granule is switched.
  initial begin
    int    kind;
    int    full_len;
    bit    is_mono;
    bit    burst;
    fill_t fill;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Bytes before any frame start must be dropped.
    send_byte(8'hFF, 1'b0, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    // A mono frame of all ones: every field at its maximum, both granules
    // switched, so block type, mixed flag and the subblock gains appear.
    send_frame(1'b1, 17, FILL_ONES, 1'b0);
    // A byte after the frame's last field must be dropped.
    send_byte(8'hA5, 1'b0, 1'b1, 1'b0);
    // A stereo frame of zeros, cut short: the next frame start abandons it.
    send_frame(1'b0, 4, FILL_ZEROS, 1'b0);

    // Let the block drain completely before the random part begins.
    push <= 1'b0;
    while (fields_waiting != 0) @(negedge clk);

    // Random part. Most traffic is whole frames with random content, some
    // followed by stray bytes; the rest is truncated frames, cut off by the
    // next frame start, and loose bytes that land inside or outside a frame.
    while (frame_bytes_sent < FRAME_BYTES) begin
      kind     = $urandom_range(99);
      is_mono  = 1'($urandom_range(1));
      burst    = ($urandom_range(4) == 0);
      full_len = is_mono ? 17 : 32;
      case ($urandom_range(9))
        0:       fill = FILL_ONES;
        1:       fill = FILL_ZEROS;
        default: fill = FILL_RANDOM;
      endcase
      if (kind < 75) begin
        send_frame(is_mono, full_len, fill, burst);
        repeat ($urandom_range(2)) begin
          send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), burst);
        end
      end else if (kind < 92) begin
        send_frame(is_mono, $urandom_range(full_len - 1, 1), fill, burst);
      end else begin
        repeat ($urandom_range(3, 1)) begin
          send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), burst);
        end
      end
    end

    // Wait for every expected field, then a little longer so that any
    // stray result still in flight is caught.
    push <= 1'b0;
    while (fields_waiting != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (error_count == 0 && fields_waiting == 0) begin
      $display("mp3_side_info_parser_test: done, clean");
    end else begin
      $display("mp3_side_info_parser_test: done, errors");
    end
    $finish;
  end

  // Receiver. Pop is offered with random gaps; twice it is held low for a
  // long stretch while the sender keeps going, so the output queue fills,
  // the extractor stalls and finally full is raised at the input.
  initial begin
    int taken;
    int gap;
    bit burst;
    taken = 0;
    burst = 1'b0;
    forever begin
      pop <= 1'b1;
      do @(posedge clk); while (rst || empty !== 1'b0);
      taken++;
      @(negedge clk);
      if (taken % 32 == 0) burst = ($urandom_range(3) == 0);
      if (taken == 60 || taken == 250) begin
        gap = HOLD_OFF;
      end else begin
        gap = pick_gap(burst);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("mp3_side_info_parser_test: done, errors");
    $finish;
  end

endmodule
